[src/xkma_pkg.sv]
// shared constants, codes and controller/datapath handshake types for the id allocator
package xkma_pkg;

  // id space and fullness tree geometry
  localparam int ID_BITS   = 10;
  localparam int HEAP_BITS = ID_BITS + 1;
  localparam int HEAP_SIZE = 1 << HEAP_BITS;
  localparam int LVL_BITS  = $clog2(ID_BITS + 1);
  localparam int CMD_W     = 2;
  localparam int ST_W      = 2;

  // transaction commands
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_XOR    = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_TAKEN = 2'd2;

  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [HEAP_BITS-1:0] heap_t;
  typedef logic [LVL_BITS-1:0]  lvl_t;

  localparam heap_t ROOT_IDX = heap_t'(1);

  // controller to datapath commands
  typedef struct packed {
    logic            clr_wr;
    logic            load;
    logic            key_xor;
    logic            is_alloc;
    logic            step;
    logic            up_wr;
    logic            fin;
    logic            fin_id;
    logic [ST_W-1:0] fin_st;
    lvl_t            lvl;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic root_full;
    logic leaf_taken;
    logic sib_full;
    logic at_root;
    logic out_free;
  } dp_sts_t;

endpackage

[src/xkma_in_if.sv]
// request channel: command and value with valid/ready
interface xkma_in_if;
  logic                       valid;
  logic                       ready;
  logic [xkma_pkg::CMD_W-1:0] cmd;
  logic [9:0]                 value;

  modport source (output valid, cmd, value, input ready);
  modport sink (input valid, cmd, value, output ready);
endinterface

[src/xkma_out_if.sv]
// result channel: id and status with valid/ready
interface xkma_out_if;
  logic                      valid;
  logic                      ready;
  logic [9:0]                id;
  logic [xkma_pkg::ST_W-1:0] status;

  modport source (output valid, id, status, input ready);
  modport sink (input valid, id, status, output ready);
endinterface

[src/xkma_datapath.sv]
// fullness tree memory, descent path registers, xor key and result register
module xkma_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [9:0]                   in_value,
  input  xkma_pkg::dp_cmd_t            cmd,
  output xkma_pkg::dp_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [9:0]                   out_id,
  output logic [xkma_pkg::ST_W-1:0]    out_status
);

  // full flag per heap index; leaves sit at the bottom half
  logic mem [xkma_pkg::HEAP_SIZE];

  xkma_pkg::heap_t clr_cnt_r, clr_cnt_nxt;
  xkma_pkg::heap_t node_r, node_nxt;
  xkma_pkg::id_t   key_r, key_nxt;
  xkma_pkg::id_t   val_r;
  xkma_pkg::id_t   leaf_r;
  xkma_pkg::id_t   sib_r;
  xkma_pkg::id_t   id_r;
  logic [xkma_pkg::ST_W-1:0] st_r;
  logic            out_valid_r, out_valid_nxt;
  logic            rd_a_r, rd_b_r;

  xkma_pkg::heap_t nd, rd_addr_a, rd_addr_b, wr_addr;
  xkma_pkg::id_t   pos_ins;
  logic            wr_en, wr_data;
  logic            kb, pref_full, dir, chosen_full, sib_of_path;

  // direction choice for one level of the descent
  always_comb begin
    pos_ins     = val_r ^ key_r;
    kb          = key_r[cmd.lvl];
    pref_full   = kb ? rd_b_r : rd_a_r;
    dir         = cmd.is_alloc ? (kb ^ pref_full) : pos_ins[cmd.lvl];
    chosen_full = dir ? rd_b_r : rd_a_r;
    sib_of_path = dir ? rd_a_r : rd_b_r;
    node_nxt    = {node_r[xkma_pkg::HEAP_BITS-2:0], dir};
  end

  // read both children of the node the next level starts from
  always_comb begin
    nd        = cmd.step ? node_nxt : node_r;
    rd_addr_a = cmd.load ? xkma_pkg::ROOT_IDX : {nd[xkma_pkg::HEAP_BITS-2:0], 1'b0};
    rd_addr_b = {nd[xkma_pkg::HEAP_BITS-2:0], 1'b1};
    wr_en     = cmd.clr_wr | cmd.up_wr;
    wr_addr   = cmd.clr_wr ? clr_cnt_r : node_r;
    wr_data   = cmd.up_wr;
  end

  // tree memory, two registered reads and one write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // control state: clear sweep, key, output valid
  always_comb begin
    clr_cnt_nxt   = cmd.clr_wr ? clr_cnt_r + xkma_pkg::heap_t'(1) : clr_cnt_r;
    key_nxt       = (cmd.load && cmd.key_xor) ? key_r ^ in_value[xkma_pkg::ID_BITS-1:0]
                                              : key_r;
    out_valid_nxt = cmd.fin | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      key_r       <= key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // path registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_value[xkma_pkg::ID_BITS-1:0];
      node_r <= xkma_pkg::ROOT_IDX;
    end else if (cmd.step) begin
      node_r <= node_nxt;
    end else if (cmd.up_wr) begin
      node_r <= node_r >> 1;
    end
    if (cmd.step) begin
      sib_r[cmd.lvl] <= sib_of_path;
      leaf_r         <= node_nxt[xkma_pkg::ID_BITS-1:0];
    end
    if (cmd.fin) begin
      id_r <= cmd.fin_id ? (leaf_r ^ key_r) : '0;
      st_r <= cmd.fin_st;
    end
  end

  // status back to the controller
  always_comb begin
    sts.clr_last   = &clr_cnt_r;
    sts.root_full  = rd_a_r;
    sts.leaf_taken = chosen_full;
    sts.sib_full   = sib_r[cmd.lvl];
    sts.at_root    = (node_r == xkma_pkg::ROOT_IDX);
    sts.out_free   = ~out_valid_r | out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_id     = id_r;
  assign out_status = st_r;

endmodule

[src/xkma_ctrl.sv]
// sequencer: clear sweep, root check, level-by-level descent, upward fullness writes
module xkma_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [xkma_pkg::CMD_W-1:0]  in_cmd,
  output logic                        in_ready,
  output xkma_pkg::dp_cmd_t           cmd,
  input  xkma_pkg::dp_sts_t           sts
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_DESC = 3'd3;
  localparam logic [2:0] S_UP   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                state_r, state_nxt;
  xkma_pkg::lvl_t            lvl_r, lvl_nxt;
  logic                      alloc_r, alloc_nxt;
  logic                      fin_id_r, fin_id_nxt;
  logic [xkma_pkg::ST_W-1:0] res_r, res_nxt;

  // next state and command decode
  always_comb begin
    state_nxt    = state_r;
    lvl_nxt      = lvl_r;
    alloc_nxt    = alloc_r;
    fin_id_nxt   = fin_id_r;
    res_nxt      = res_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.lvl      = lvl_r;
    cmd.is_alloc = alloc_r;
    cmd.fin_id   = fin_id_r;
    cmd.fin_st   = res_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.key_xor = (in_cmd == xkma_pkg::CMD_XOR);
          alloc_nxt   = (in_cmd == xkma_pkg::CMD_ALLOC);
          if (in_cmd == xkma_pkg::CMD_ALLOC || in_cmd == xkma_pkg::CMD_INSERT) begin
            state_nxt = S_ROOT;
          end else begin
            res_nxt    = xkma_pkg::ST_OK;
            fin_id_nxt = 1'b0;
            state_nxt  = S_FIN;
          end
        end
      end
      S_ROOT: begin
        if (alloc_r && sts.root_full) begin
          res_nxt    = xkma_pkg::ST_FULL;
          fin_id_nxt = 1'b0;
          state_nxt  = S_FIN;
        end else begin
          lvl_nxt   = xkma_pkg::lvl_t'(xkma_pkg::ID_BITS - 1);
          state_nxt = S_DESC;
        end
      end
      S_DESC: begin
        cmd.step = 1'b1;
        if (lvl_r == '0) begin
          if (!alloc_r && sts.leaf_taken) begin
            res_nxt    = xkma_pkg::ST_TAKEN;
            fin_id_nxt = 1'b0;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_UP;
          end
        end else begin
          lvl_nxt = lvl_r - xkma_pkg::lvl_t'(1);
        end
      end
      S_UP: begin
        // a parent becomes full only when the sibling already is
        cmd.up_wr = 1'b1;
        if (sts.at_root || !sts.sib_full) begin
          res_nxt    = xkma_pkg::ST_OK;
          fin_id_nxt = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          lvl_nxt = lvl_r + xkma_pkg::lvl_t'(1);
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      lvl_r    <= '0;
      alloc_r  <= 1'b0;
      fin_id_r <= 1'b0;
      res_r    <= xkma_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      lvl_r    <= lvl_nxt;
      alloc_r  <= alloc_nxt;
      fin_id_r <= fin_id_nxt;
      res_r    <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  // a result is only loaded when the output register can take it
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> sts.out_free)
    else $error("result loaded while output register busy");

  // descent level stays inside the id width
  a_desc_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DESC |-> lvl_r < xkma_pkg::lvl_t'(xkma_pkg::ID_BITS))
    else $error("descent level out of range");

  // the upward pass ends in the finish state, never back in the descent
  a_up_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP |=> (state_r == S_UP || state_r == S_FIN))
    else $error("bad exit from upward update");

  // a taken status comes straight from the descent, so a taken insert never writes the tree
  a_taken_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && $past(state_r) != S_FIN && res_r == xkma_pkg::ST_TAKEN)
      |-> $past(state_r) == S_DESC)
    else $error("taken status reached without descent");
`endif

endmodule

[src/xor_keyed_min_free_id_allocator.sv]
// top level: min-free id allocator with global xor remap
// Keeps a set of 10-bit ids in a fullness tree (one flag per heap node, leaves at the
// bottom) plus an accumulated xor key; stored id = physical position xor key. After
// reset a clearing sweep writes all 2048 flags before the first transaction is taken.
// An xor transaction and an allocate on a full set go to their result without a tree
// descent. Allocate and insert read both children of one tree node per cycle from a
// two-read-port flag memory, descending one level at a time over the 10 id bits; the
// upward fullness update writes one node per cycle and stops at the first ancestor that
// stays non-full or at the root. A taken insert ends after the descent.
// A finished result sits in an output register; one transaction is in work at a time.
module xor_keyed_min_free_id_allocator (
  input logic       clk,
  input logic       rst_n,
  xkma_in_if.sink   in_if,
  xkma_out_if.source out_if
);

  xkma_pkg::dp_cmd_t cmd;
  xkma_pkg::dp_sts_t sts;

  // sequencer
  xkma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_cmd   (in_if.cmd),
    .in_ready (in_if.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // tree memory and result register
  xkma_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_if.value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_id     (out_if.id),
    .out_status (out_if.status)
  );

endmodule
